### src/button_auto_repeat_unit_macros.svh
// ----------------------------------------------------------------------------
// button auto-repeat unit assertion macros
// shared concurrent assertion forms, clocked on clk, disabled in reset
// ----------------------------------------------------------------------------
`ifndef BUTTON_AUTO_REPEAT_UNIT_MACROS_SVH
`define BUTTON_AUTO_REPEAT_UNIT_MACROS_SVH

// same-cycle implication
`define BAR_ASSERT_NOW(label, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error(msg);

// next-cycle implication
`define BAR_ASSERT_NEXT(label, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

### src/bar_pkg.sv
// ----------------------------------------------------------------------------
// bar_pkg
// types and constants shared by the button auto-repeat unit
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

package bar_pkg;

	localparam int NUM_BUTTONS_DEF = 8;
	localparam int TIME_W          = 32;
	localparam int CFG_W           = 16;
	localparam int CFG_IDX_W       = 1;

	localparam logic [CFG_W-1:0] RESET_DELAY_MS    = 16'd1000;
	localparam logic [CFG_W-1:0] RESET_INTERVAL_MS = 16'd20;

	typedef enum logic [1:0] {
		MODE_IDLE   = 2'd0,
		MODE_WAIT   = 2'd1,
		MODE_REPEAT = 2'd2
	} mode_t;

	typedef enum logic [CFG_IDX_W-1:0] {
		REG_REPEAT_DELAY    = 1'b0,
		REG_REPEAT_INTERVAL = 1'b1
	} cfg_reg_t;

	typedef struct packed {
		logic [CFG_W-1:0] repeat_delay_ms;
		logic [CFG_W-1:0] repeat_interval_ms;
	} cfg_t;

endpackage

`default_nettype wire

### src/bar_lane.sv
// ----------------------------------------------------------------------------
// bar_lane
// per-button typematic core: mode, press and last pulse timestamps
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module bar_lane
	import bar_pkg::*;
(
	input  wire logic              clk,
	input  wire logic              arst_n,
	input  wire logic              fire,
	input  wire logic              held,
	input  wire logic [TIME_W-1:0] now_ms,
	input  wire cfg_t              cfg,
	output logic                   pulse
);

	mode_t             mode_q;
	mode_t             mode_d;
	logic [TIME_W-1:0] press_time_q;
	logic [TIME_W-1:0] last_pulse_q;
	logic [TIME_W-1:0] since_press;
	logic [TIME_W-1:0] since_pulse;
	logic              upd_press;
	logic              upd_last;

	assign since_press = now_ms - press_time_q;
	assign since_pulse = now_ms - last_pulse_q;

	always_comb begin
		pulse     = 1'b0;
		mode_d    = mode_q;
		upd_press = 1'b0;
		upd_last  = 1'b0;
		if (!held) begin
			mode_d = MODE_IDLE;
		end else begin
			case (mode_q)
				MODE_WAIT: begin
					if (since_press > TIME_W'(cfg.repeat_delay_ms)) begin
						pulse    = 1'b1;
						mode_d   = MODE_REPEAT;
						upd_last = 1'b1;
					end
				end
				MODE_REPEAT: begin
					if (since_pulse > TIME_W'(cfg.repeat_interval_ms)) begin
						pulse    = 1'b1;
						upd_last = 1'b1;
					end
				end
				default: begin
					pulse     = 1'b1;
					mode_d    = MODE_WAIT;
					upd_press = 1'b1;
				end
			endcase
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			mode_q <= MODE_IDLE;
		end else if (fire) begin
			mode_q <= mode_d;
		end
	end

	// timestamps are only read after being written on entry to that mode
	always_ff @(posedge clk) begin
		if (fire && upd_press) begin
			press_time_q <= now_ms;
		end
		if (fire && upd_last) begin
			last_pulse_q <= now_ms;
		end
	end

endmodule

`default_nettype wire

### src/bar_merge.sv
// ----------------------------------------------------------------------------
// bar_merge
// gathers lane pulses into the result and buffers it in a two-entry skid
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none
`include "button_auto_repeat_unit_macros.svh"

module bar_merge
	import bar_pkg::*;
#(
	parameter int NUM_BUTTONS = NUM_BUTTONS_DEF
) (
	input  wire logic                   clk,
	input  wire logic                   arst_n,
	input  wire logic                   in_valid,
	output logic                        in_ready,
	input  wire logic [NUM_BUTTONS-1:0] lane_pulse,
	output logic                        out_valid,
	input  wire logic                   out_ready,
	output logic [NUM_BUTTONS-1:0]      out_mask
);

	logic                   out_valid_q;
	logic [NUM_BUTTONS-1:0] out_mask_q;
	logic                   skid_valid_q;
	logic [NUM_BUTTONS-1:0] skid_mask_q;
	logic                   push;
	logic                   pop;

	assign in_ready  = !skid_valid_q;
	assign push      = in_valid && in_ready;
	assign pop       = out_valid_q && out_ready;
	assign out_valid = out_valid_q;
	assign out_mask  = out_mask_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q  <= 1'b0;
			skid_valid_q <= 1'b0;
		end else if (!out_valid_q || pop) begin
			out_valid_q  <= skid_valid_q || push;
			skid_valid_q <= 1'b0;
		end else if (push) begin
			skid_valid_q <= 1'b1;
		end
	end

	always_ff @(posedge clk) begin
		if (!out_valid_q || pop) begin
			out_mask_q <= skid_valid_q ? skid_mask_q : lane_pulse;
		end else if (push) begin
			skid_mask_q <= lane_pulse;
		end
	end

	`BAR_ASSERT_NOW(a_skid_behind_out, skid_valid_q, out_valid_q, "skid full with output empty")
	`BAR_ASSERT_NEXT(a_stall_fills_skid, push && out_valid_q && !out_ready, skid_valid_q,
		"stalled transfer not held in skid")
	`BAR_ASSERT_NEXT(a_skid_drains, pop && skid_valid_q,
		out_valid_q && !skid_valid_q && out_mask_q == $past(skid_mask_q),
		"skid entry lost on drain")

endmodule

`default_nettype wire

### src/button_auto_repeat_unit.sv
// ----------------------------------------------------------------------------
// button_auto_repeat_unit
// typematic auto-repeat for a bank of held buttons
// ----------------------------------------------------------------------------
// One sample (timestamp and held mask) is taken every clock cycle while the
// input is not stalled; every button has its own lane that updates its mode
// and timestamps on the transfer, and the pulse mask is registered into the
// output buffer. A two-entry output buffer lets a sample be taken while
// one result still waits downstream, so input stalls only when both
// entries are full. Configuration writes take effect from the next sample.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module button_auto_repeat_unit
	import bar_pkg::*;
#(
	parameter int NUM_BUTTONS = NUM_BUTTONS_DEF,
	localparam int IN_W  = ((TIME_W + NUM_BUTTONS + 7) / 8) * 8,
	localparam int OUT_W = ((NUM_BUTTONS + 7) / 8) * 8
) (
	input  wire logic                 clk,
	input  wire logic                 arst_n,
	input  wire logic                 cfg_we,
	input  wire logic [CFG_IDX_W-1:0] cfg_index,
	input  wire logic [CFG_W-1:0]     cfg_data,
	input  wire logic                 s_axis_tvalid,
	output logic                      s_axis_tready,
	input  wire logic [IN_W-1:0]      s_axis_tdata,  // now_ms, held_mask
	output logic                      m_axis_tvalid,
	input  wire logic                 m_axis_tready,
	output logic [OUT_W-1:0]          m_axis_tdata   // press_mask
);

	cfg_t                   cfg_q;
	logic                   fire;
	logic [TIME_W-1:0]      now_ms;
	logic [NUM_BUTTONS-1:0] held_mask;
	logic [NUM_BUTTONS-1:0] lane_pulse;
	logic [NUM_BUTTONS-1:0] press_mask;

	assign now_ms    = s_axis_tdata[TIME_W-1:0];
	assign held_mask = s_axis_tdata[TIME_W +: NUM_BUTTONS];
	assign fire      = s_axis_tvalid && s_axis_tready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.repeat_delay_ms    <= RESET_DELAY_MS;
			cfg_q.repeat_interval_ms <= RESET_INTERVAL_MS;
		end else if (cfg_we) begin
			case (cfg_reg_t'(cfg_index))
				REG_REPEAT_DELAY:    cfg_q.repeat_delay_ms    <= cfg_data;
				REG_REPEAT_INTERVAL: cfg_q.repeat_interval_ms <= cfg_data;
				default: begin
				end
			endcase
		end
	end

	for (genvar i = 0; i < NUM_BUTTONS; i++) begin : g_lane
		bar_lane u_lane (
			.clk    (clk),
			.arst_n (arst_n),
			.fire   (fire),
			.held   (held_mask[i]),
			.now_ms (now_ms),
			.cfg    (cfg_q),
			.pulse  (lane_pulse[i])
		);
	end

	bar_merge #(
		.NUM_BUTTONS (NUM_BUTTONS)
	) u_merge (
		.clk        (clk),
		.arst_n     (arst_n),
		.in_valid   (s_axis_tvalid),
		.in_ready   (s_axis_tready),
		.lane_pulse (lane_pulse),
		.out_valid  (m_axis_tvalid),
		.out_ready  (m_axis_tready),
		.out_mask   (press_mask)
	);

	assign m_axis_tdata = OUT_W'(press_mask);

endmodule

`default_nettype wire
